// ----- hw/rtl/prf_pkg.sv -----
// prf_pkg: shared constants, types and tables for the rho factor finder.
// Used by the channel interfaces and the core. No dependencies.
package prf_pkg;

    localparam int NUM_BITS        = 64;
    localparam int IDX_W           = $clog2(NUM_BITS);
    localparam int NUMBER_W        = 64;
    localparam int FACTOR_W        = 64;
    localparam int STATUS_W        = 2;
    localparam int MAX_STEPS_W     = 20;
    localparam int NUM_BASES       = 12;
    localparam int BASE_IDX_W      = $clog2(NUM_BASES);
    localparam int BASE_W          = 6;

    localparam logic [MAX_STEPS_W-1:0] MAX_STEPS_RESET = MAX_STEPS_W'(1000000);

    typedef logic [STATUS_W-1:0] status_t;

    localparam status_t STATUS_PRIME   = 2'd0;
    localparam status_t STATUS_EVEN    = 2'd1;
    localparam status_t STATUS_FOUND   = 2'd2;
    localparam status_t STATUS_TIMEOUT = 2'd3;

    // Miller-Rabin witness set, exact for 64-bit inputs
    function automatic logic [BASE_W-1:0] mr_base(input logic [BASE_IDX_W-1:0] idx);
        logic [BASE_W-1:0] b;
        case (idx)
            4'd0:    b = 6'd2;
            4'd1:    b = 6'd3;
            4'd2:    b = 6'd5;
            4'd3:    b = 6'd7;
            4'd4:    b = 6'd11;
            4'd5:    b = 6'd13;
            4'd6:    b = 6'd17;
            4'd7:    b = 6'd19;
            4'd8:    b = 6'd23;
            4'd9:    b = 6'd29;
            4'd10:   b = 6'd31;
            4'd11:   b = 6'd37;
            default: b = 6'd2;
        endcase
        return b;
    endfunction

endpackage

// ----- hw/rtl/prf_if.sv -----
// prf_in_if / prf_out_if: valid-ready channels of the rho factor finder.
// Depends on prf_pkg.
interface prf_in_if;
    logic                            valid;
    logic                            ready;
    logic [prf_pkg::NUMBER_W-1:0]    number;

    modport source (output valid, output number, input ready);
    modport sink   (input valid, input number, output ready);
endinterface

interface prf_out_if;
    logic                            valid;
    logic                            ready;
    logic [prf_pkg::FACTOR_W-1:0]    factor;
    prf_pkg::status_t                status;

    modport source (output valid, output factor, output status, input ready);
    modport sink   (input valid, input factor, input status, output ready);
endinterface

// ----- hw/rtl/pollard_rho_factor_finder_core.sv -----
// pollard_rho_factor_finder_core: rho factor finder on one shared mulmod and gcd unit.
// Even inputs and inputs up to 37 skip Miller-Rabin after at most 12 witness compares.
// Odd inputs above 37 run Miller-Rabin: per base one modular exponentiation
// plus up to NUM_BITS - 2 squarings; composites usually stop on base 2.
// Each rho step runs three mulmods plus up to two gcds.
// One number at a time; reset (rst_n, async low): idle, no result, max_steps = 1000000.
module pollard_rho_factor_finder_core (
    input  logic                              clk,
    input  logic                              rst_n,
    prf_in_if.sink                            req,
    prf_out_if.source                         rsp,
    input  logic                              cfg_we,
    input  logic [prf_pkg::MAX_STEPS_W-1:0]   cfg_wdata
);

    localparam int W = prf_pkg::NUM_BITS;

    typedef enum logic [4:0] {
        S_IDLE, S_PRE_CHK, S_MR_STRIP, S_MR_BASE, S_POW_STEP, S_POW_GOTR,
        S_POW_GOTB, S_MR_CHECK, S_MR_SQ_CHK, S_MR_SQ_GOT, S_CLASSIFY, S_RHO_SEED,
        S_RHO_LOOP, S_RHO_NEXT, S_RHO_T, S_RHO_H1, S_RHO_H2, S_GCD_START, S_GCD_RUN,
        S_MUL_RUN, S_FINISH
    } state_t;

    state_t                              state_reg, ret_reg;
    logic [prf_pkg::MAX_STEPS_W-1:0]     max_steps_reg, step_count_reg;
    logic [W-1:0]                        n_reg, nm1_reg, d_reg;
    logic [prf_pkg::IDX_W-1:0]           s_reg, k_reg;
    logic [prf_pkg::BASE_IDX_W-1:0]      bi_reg;
    logic [W-1:0]                        pr_reg, pb_reg, pe_reg, x_reg;
    logic [W-1:0]                        ma_reg, mb_reg, mr_reg;
    logic [W-1:0]                        tortoise_reg, hare_reg, seed_reg, divisor_reg;
    logic [W-1:0]                        gu_reg, gv_reg;
    logic                                gsel_reg;
    logic [W-1:0]                        res_factor_reg;
    prf_pkg::status_t                    res_status_reg;
    logic                                out_valid_reg;
    logic [prf_pkg::FACTOR_W-1:0]        out_factor_reg;
    prf_pkg::status_t                    out_status_reg;

    // a, b < m
    function automatic logic [W-1:0] add_mod(input logic [W-1:0] a, input logic [W-1:0] b,
                                             input logic [W-1:0] m);
        logic [W:0] s;
        logic [W:0] t;
        s = {1'b0, a} + {1'b0, b};
        t = s - {1'b0, m};
        return (s >= {1'b0, m}) ? t[W-1:0] : s[W-1:0];
    endfunction

    function automatic logic [W-1:0] rho_map(input logic [W-1:0] r, input logic [W-1:0] m);
        logic [W:0] v;
        logic [W:0] t;
        v = {1'b0, r} + (W+1)'(1);
        t = v - {1'b0, m};
        return (v >= {1'b0, m}) ? t[W-1:0] : v[W-1:0];
    endfunction

    logic [W-1:0]                 mul_r_nx, mul_a_nx, map_mr, diff, gcd_val;
    logic [prf_pkg::BASE_W-1:0]   base;
    logic                         step_go;

    always_comb
    begin
        mul_r_nx = add_mod(mr_reg, ma_reg, n_reg);
        mul_a_nx = add_mod(ma_reg, ma_reg, n_reg);
        map_mr   = rho_map(mr_reg, n_reg);
        diff     = (tortoise_reg < hare_reg) ? hare_reg - tortoise_reg
                                             : tortoise_reg - hare_reg;
        gcd_val  = (gu_reg == '0) ? gv_reg : gu_reg;
        base     = prf_pkg::mr_base(bi_reg);
        step_go  = (divisor_reg == W'(1)) && (step_count_reg < max_steps_reg);
    end

    assign req.ready  = (state_reg == S_IDLE);
    assign rsp.valid  = out_valid_reg;
    assign rsp.factor = out_factor_reg;
    assign rsp.status = out_status_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            ret_reg        <= S_IDLE;
            max_steps_reg  <= prf_pkg::MAX_STEPS_RESET;
            step_count_reg <= '0;
            n_reg          <= '0;
            nm1_reg        <= '0;
            d_reg          <= '0;
            s_reg          <= '0;
            k_reg          <= '0;
            bi_reg         <= '0;
            pr_reg         <= '0;
            pb_reg         <= '0;
            pe_reg         <= '0;
            x_reg          <= '0;
            ma_reg         <= '0;
            mb_reg         <= '0;
            mr_reg         <= '0;
            tortoise_reg   <= '0;
            hare_reg       <= '0;
            seed_reg       <= '0;
            divisor_reg    <= W'(1);
            gu_reg         <= '0;
            gv_reg         <= '0;
            gsel_reg       <= 1'b0;
            res_factor_reg <= '0;
            res_status_reg <= prf_pkg::STATUS_PRIME;
            out_valid_reg  <= 1'b0;
            out_factor_reg <= '0;
            out_status_reg <= prf_pkg::STATUS_PRIME;
        end
        else
        begin
            if (cfg_we)
                max_steps_reg <= cfg_wdata;
            // S_FINISH drives the valid flag itself
            if (out_valid_reg && rsp.ready && state_reg != S_FINISH)
                out_valid_reg <= 1'b0;

            unique case (state_reg)
                S_IDLE:
                begin
                    if (req.valid)
                    begin
                        n_reg     <= req.number[W-1:0];
                        nm1_reg   <= req.number[W-1:0] - W'(1);
                        d_reg     <= req.number[W-1:0] - W'(1);
                        s_reg     <= '0;
                        bi_reg    <= '0;
                        state_reg <= S_PRE_CHK;
                    end
                end
                // compare against each witness, one per cycle
                S_PRE_CHK:
                begin
                    if (n_reg < W'(2))
                        state_reg <= S_CLASSIFY;
                    else if (n_reg == W'(base))
                    begin
                        res_factor_reg <= n_reg;
                        res_status_reg <= prf_pkg::STATUS_PRIME;
                        state_reg      <= S_FINISH;
                    end
                    else if (bi_reg == prf_pkg::BASE_IDX_W'(prf_pkg::NUM_BASES - 1))
                        // below the largest witness or even: composite, no Miller-Rabin
                        state_reg <= (n_reg < W'(base) || !n_reg[0]) ? S_CLASSIFY
                                                                     : S_MR_STRIP;
                    else
                        bi_reg <= bi_reg + 1'b1;
                end
                S_MR_STRIP:
                begin
                    if (!d_reg[0])
                    begin
                        d_reg <= d_reg >> 1;
                        s_reg <= s_reg + 1'b1;
                    end
                    else
                    begin
                        bi_reg    <= '0;
                        state_reg <= S_MR_BASE;
                    end
                end
                S_MR_BASE:
                begin
                    pr_reg    <= W'(1);
                    pb_reg    <= W'(base);
                    pe_reg    <= d_reg;
                    state_reg <= S_POW_STEP;
                end
                S_POW_STEP:
                begin
                    if (pe_reg == '0)
                    begin
                        x_reg     <= pr_reg;
                        state_reg <= S_MR_CHECK;
                    end
                    else
                    begin
                        ma_reg    <= pe_reg[0] ? pr_reg : pb_reg;
                        mb_reg    <= pb_reg;
                        mr_reg    <= '0;
                        ret_reg   <= pe_reg[0] ? S_POW_GOTR : S_POW_GOTB;
                        state_reg <= S_MUL_RUN;
                    end
                end
                S_POW_GOTR:
                begin
                    pr_reg    <= mr_reg;
                    ma_reg    <= pb_reg;
                    mb_reg    <= pb_reg;
                    mr_reg    <= '0;
                    ret_reg   <= S_POW_GOTB;
                    state_reg <= S_MUL_RUN;
                end
                S_POW_GOTB:
                begin
                    pb_reg    <= mr_reg;
                    pe_reg    <= pe_reg >> 1;
                    state_reg <= S_POW_STEP;
                end
                S_MR_CHECK:
                begin
                    if (x_reg == W'(1) || x_reg == nm1_reg)
                    begin
                        if (bi_reg == prf_pkg::BASE_IDX_W'(prf_pkg::NUM_BASES - 1))
                        begin
                            res_factor_reg <= n_reg;
                            res_status_reg <= prf_pkg::STATUS_PRIME;
                            state_reg      <= S_FINISH;
                        end
                        else
                        begin
                            bi_reg    <= bi_reg + 1'b1;
                            state_reg <= S_MR_BASE;
                        end
                    end
                    else
                    begin
                        k_reg     <= prf_pkg::IDX_W'(1);
                        state_reg <= S_MR_SQ_CHK;
                    end
                end
                S_MR_SQ_CHK:
                begin
                    if (k_reg < s_reg)
                    begin
                        ma_reg    <= x_reg;
                        mb_reg    <= x_reg;
                        mr_reg    <= '0;
                        ret_reg   <= S_MR_SQ_GOT;
                        state_reg <= S_MUL_RUN;
                    end
                    else
                        state_reg <= S_CLASSIFY;
                end
                S_MR_SQ_GOT:
                begin
                    x_reg <= mr_reg;
                    if (mr_reg == nm1_reg)
                    begin
                        if (bi_reg == prf_pkg::BASE_IDX_W'(prf_pkg::NUM_BASES - 1))
                        begin
                            res_factor_reg <= n_reg;
                            res_status_reg <= prf_pkg::STATUS_PRIME;
                            state_reg      <= S_FINISH;
                        end
                        else
                        begin
                            bi_reg    <= bi_reg + 1'b1;
                            state_reg <= S_MR_BASE;
                        end
                    end
                    else
                    begin
                        k_reg     <= k_reg + 1'b1;
                        state_reg <= S_MR_SQ_CHK;
                    end
                end
                S_CLASSIFY:
                begin
                    if (!n_reg[0])
                    begin
                        res_factor_reg <= W'(2);
                        res_status_reg <= prf_pkg::STATUS_EVEN;
                        state_reg      <= S_FINISH;
                    end
                    else if (n_reg == W'(1))
                    begin
                        res_factor_reg <= W'(1);
                        res_status_reg <= prf_pkg::STATUS_TIMEOUT;
                        state_reg      <= S_FINISH;
                    end
                    else
                    begin
                        seed_reg  <= W'(2);
                        state_reg <= S_RHO_SEED;
                    end
                end
                S_RHO_SEED:
                begin
                    tortoise_reg   <= seed_reg;
                    hare_reg       <= seed_reg;
                    divisor_reg    <= W'(1);
                    step_count_reg <= '0;
                    state_reg      <= S_RHO_LOOP;
                end
                S_RHO_LOOP:
                begin
                    if (step_go)
                    begin
                        ma_reg    <= tortoise_reg;
                        mb_reg    <= tortoise_reg;
                        mr_reg    <= '0;
                        ret_reg   <= S_RHO_T;
                        state_reg <= S_MUL_RUN;
                    end
                    else if (divisor_reg != n_reg)
                    begin
                        res_factor_reg <= divisor_reg;
                        res_status_reg <= (divisor_reg == W'(1)) ? prf_pkg::STATUS_TIMEOUT
                                                                 : prf_pkg::STATUS_FOUND;
                        state_reg      <= S_FINISH;
                    end
                    else
                    begin
                        seed_reg  <= seed_reg + W'(1);
                        state_reg <= S_RHO_NEXT;
                    end
                end
                S_RHO_NEXT:
                begin
                    if (seed_reg >= n_reg)
                    begin
                        divisor_reg    <= W'(1);
                        res_factor_reg <= W'(1);
                        res_status_reg <= prf_pkg::STATUS_TIMEOUT;
                        state_reg      <= S_FINISH;
                    end
                    else
                        state_reg <= S_RHO_SEED;
                end
                S_RHO_T:
                begin
                    tortoise_reg <= map_mr;
                    ma_reg       <= hare_reg;
                    mb_reg       <= hare_reg;
                    mr_reg       <= '0;
                    ret_reg      <= S_RHO_H1;
                    state_reg    <= S_MUL_RUN;
                end
                S_RHO_H1:
                begin
                    ma_reg    <= map_mr;
                    mb_reg    <= map_mr;
                    mr_reg    <= '0;
                    ret_reg   <= S_RHO_H2;
                    state_reg <= S_MUL_RUN;
                end
                S_RHO_H2:
                begin
                    hare_reg  <= map_mr;
                    state_reg <= S_GCD_START;
                end
                S_GCD_START:
                begin
                    gu_reg    <= diff;
                    gv_reg    <= n_reg;
                    gsel_reg  <= 1'b0;
                    state_reg <= S_GCD_RUN;
                end
                // binary gcd against the odd modulus: shift or subtract per cycle
                S_GCD_RUN:
                begin
                    if (gu_reg == '0 || gu_reg == gv_reg)
                    begin
                        if (!gsel_reg && gcd_val == W'(1))
                        begin
                            gu_reg   <= tortoise_reg;
                            gv_reg   <= n_reg;
                            gsel_reg <= 1'b1;
                        end
                        else
                        begin
                            divisor_reg    <= gcd_val;
                            step_count_reg <= step_count_reg + 1'b1;
                            state_reg      <= S_RHO_LOOP;
                        end
                    end
                    else if (!gu_reg[0])
                        gu_reg <= gu_reg >> 1;
                    else if (!gv_reg[0])
                        gv_reg <= gv_reg >> 1;
                    else if (gu_reg > gv_reg)
                        gu_reg <= gu_reg - gv_reg;
                    else
                        gv_reg <= gv_reg - gu_reg;
                end
                // shift-and-add modular multiply, one multiplier bit per cycle
                S_MUL_RUN:
                begin
                    if (mb_reg == '0)
                        state_reg <= ret_reg;
                    else
                    begin
                        if (mb_reg[0])
                            mr_reg <= mul_r_nx;
                        ma_reg <= mul_a_nx;
                        mb_reg <= mb_reg >> 1;
                    end
                end
                S_FINISH:
                begin
                    if (!out_valid_reg || rsp.ready)
                    begin
                        out_valid_reg  <= 1'b1;
                        out_factor_reg <= prf_pkg::FACTOR_W'(res_factor_reg);
                        out_status_reg <= res_status_reg;
                        state_reg      <= S_IDLE;
                    end
                end
                default:
                    state_reg <= S_IDLE;
            endcase
        end
    end

    a_even_factor: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_status_reg == prf_pkg::STATUS_EVEN)
            |-> out_factor_reg == prf_pkg::FACTOR_W'(2))
        else $error("even status without factor 2");

    a_timeout_factor: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_status_reg == prf_pkg::STATUS_TIMEOUT)
            |-> out_factor_reg == prf_pkg::FACTOR_W'(1))
        else $error("timeout status without factor 1");

    a_mul_reduced: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_MUL_RUN) |-> (ma_reg < n_reg && mr_reg < n_reg))
        else $error("mulmod operand not reduced");

    a_seed_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_RHO_SEED) |-> (seed_reg < n_reg && seed_reg >= W'(2)))
        else $error("rho seed out of range");

endmodule
